// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define UPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UPF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define UPF_ASSERT(label, prop, msg)
`define UPF_ASSERT_NEVER(label, cond, msg)
`endif

`endif

// ===== src/upf_pkg.sv =====
package upf_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 16;
  localparam int unsigned PortW    = 16;
  localparam int unsigned OffW     = 7;
  localparam int unsigned NibW     = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegMatchPort    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCaptureLimit = 1'd1;

  localparam logic [PortW-1:0] MatchPortRst    = 16'd53;
  localparam logic [LenW-1:0]  CaptureLimitRst = 16'd512;

  localparam logic [LenW-1:0]  PosEthTypeHi = 16'd12;
  localparam logic [LenW-1:0]  PosEthTypeLo = 16'd13;
  localparam logic [LenW-1:0]  PosIhl       = 16'd14;
  localparam logic [LenW-1:0]  PosProto     = 16'd23;
  localparam logic [LenW-1:0]  EthHdrLen    = 16'd14;
  localparam logic [LenW-1:0]  Ipv4MinEnd   = 16'd34;
  localparam logic [OffW-1:0]  EthHdrOff    = 7'd14;
  localparam logic [OffW-1:0]  UdpHdrLen    = 7'd8;
  localparam logic [LenW-1:0]  CountMax     = 16'hFFFF;
  localparam logic [15:0]      EtherTypeIpv4 = 16'h0800;
  localparam logic [ByteW-1:0] ProtoUdp     = 8'd17;

endpackage

// ===== src/upf_in_if.sv =====
interface upf_in_if;
  import upf_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== src/upf_out_if.sv =====
interface upf_out_if;
  import upf_pkg::*;

  logic            valid;
  logic            ready;
  logic            verdict;
  logic            report;
  logic [LenW-1:0] sample_length;
  logic [OffW-1:0] udp_offset;
  logic [LenW-1:0] frame_length;

  modport source (output valid, output verdict, output report, output sample_length,
                  output udp_offset, output frame_length, input ready);
  modport sink   (input valid, input verdict, input report, input sample_length,
                  input udp_offset, input frame_length, output ready);
endinterface

// ===== src/udp_port_frame_classifier.sv =====
// UDP port frame classifier.
// in_if: one Ethernet frame byte per transfer, last_byte marks the frame end.
// out_if: one verdict transfer per frame, produced from the last byte only;
//   report, sample_length and udp_offset are non-zero only for a UDP frame
//   whose source port equals match_port. frame_length saturates at 65535.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 match_port, 1 capture_limit); write only while idle.
// The verdict is valid in the cycle after the last byte transfer.
// Throughput: one byte per cycle while no verdict waits on out_if.ready, set
//   by the single output register; header fields are captured as the bytes
//   pass and the decision is made on the last byte in the same cycle.
// Reset: per-frame capture state clears, match_port returns to 53 and
//   capture_limit to 512, the output register empties.
// Stall: while a verdict waits on out_if.ready, in_if.ready is low and every
//   byte waits; a byte is taken whenever the output register is empty or
//   being drained in the same cycle.
module udp_port_frame_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [upf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [upf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  upf_in_if.sink                         in_if,
  upf_out_if.source                      out_if
);
  import upf_pkg::*;

  logic [PortW-1:0] match_port_q;
  logic [LenW-1:0]  capture_limit_q;

  logic [LenW-1:0]  byte_count_q, byte_count_d;
  logic [15:0]      ether_type_q, ether_type_d;
  logic [NibW-1:0]  header_words_q, header_words_d;
  logic [ByteW-1:0] ip_protocol_q, ip_protocol_d;
  logic [PortW-1:0] source_port_q, source_port_d;

  logic             out_valid_q;
  logic             verdict_q, verdict_d;
  logic             report_q, report_d;
  logic [LenW-1:0]  sample_q, sample_d;
  logic [OffW-1:0]  uoff_q, uoff_d;
  logic [LenW-1:0]  flen_q;

  logic             in_fire;
  logic             frame_end;
  logic [LenW-1:0]  pos;
  logic [LenW-1:0]  len;
  logic [OffW-1:0]  off;
  logic [OffW-1:0]  udp_end;
  logic [ByteW-1:0] b;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;
  assign frame_end   = in_fire && in_if.last_byte;
  assign pos         = byte_count_q;
  assign b           = in_if.frame_byte;
  assign len         = (pos == CountMax) ? CountMax : pos + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q    <= MatchPortRst;
      capture_limit_q <= CaptureLimitRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMatchPort:    match_port_q    <= cfg_wdata_i[PortW-1:0];
        RegCaptureLimit: capture_limit_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // header capture, later fields see bytes taken this transfer
  always_comb begin
    ether_type_d   = ether_type_q;
    header_words_d = header_words_q;
    ip_protocol_d  = ip_protocol_q;
    source_port_d  = source_port_q;
    if (pos == PosEthTypeHi) begin
      ether_type_d[15:8] = b;
    end else if (pos == PosEthTypeLo) begin
      ether_type_d[7:0] = b;
    end
    if (pos == PosIhl) begin
      header_words_d = b[NibW-1:0];
    end
    if (pos == PosProto) begin
      ip_protocol_d = b;
    end
    off = EthHdrOff + {1'b0, header_words_d, 2'b00};
    if (pos == {{(LenW-OffW){1'b0}}, off}) begin
      source_port_d[15:8] = b;
    end else if (pos == {{(LenW-OffW){1'b0}}, off} + 16'd1) begin
      source_port_d[7:0] = b;
    end
    byte_count_d = len;
  end

  assign udp_end = off + UdpHdrLen;

  always_comb begin
    report_d = 1'b0;
    sample_d = '0;
    uoff_d   = '0;
    if (len < EthHdrLen) begin
      verdict_d = 1'b0;
    end else if (ether_type_d != EtherTypeIpv4) begin
      verdict_d = 1'b1;
    end else if (len < Ipv4MinEnd) begin
      verdict_d = 1'b0;
    end else if (ip_protocol_d != ProtoUdp) begin
      verdict_d = 1'b1;
    end else if ({{(LenW-OffW){1'b0}}, udp_end} > len) begin
      verdict_d = 1'b0;
    end else begin
      verdict_d = 1'b1;
      if (source_port_d == match_port_q) begin
        report_d = 1'b1;
        sample_d = (len < capture_limit_q) ? len : capture_limit_q;
        uoff_d   = off;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= '0;
      ether_type_q   <= '0;
      header_words_q <= '0;
      ip_protocol_q  <= '0;
      source_port_q  <= '0;
    end else if (in_fire) begin
      if (in_if.last_byte) begin
        byte_count_q   <= '0;
        ether_type_q   <= '0;
        header_words_q <= '0;
        ip_protocol_q  <= '0;
        source_port_q  <= '0;
      end else begin
        byte_count_q   <= byte_count_d;
        ether_type_q   <= ether_type_d;
        header_words_q <= header_words_d;
        ip_protocol_q  <= ip_protocol_d;
        source_port_q  <= source_port_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      verdict_q <= verdict_d;
      report_q  <= report_d;
      sample_q  <= sample_d;
      uoff_q    <= uoff_d;
      flen_q    <= len;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.verdict       = verdict_q;
  assign out_if.report        = report_q;
  assign out_if.sample_length = sample_q;
  assign out_if.udp_offset    = uoff_q;
  assign out_if.frame_length  = flen_q;

`include "assert_macros.svh"

  `UPF_ASSERT(a_report_passes, out_valid_q && report_q |-> verdict_q, "report on dropped frame")
  `UPF_ASSERT(a_sample_capped, out_valid_q && report_q |-> sample_q <= flen_q, "sample over length")
  `UPF_ASSERT(a_frame_clears, frame_end |=> byte_count_q == '0, "frame state not cleared")
  `UPF_ASSERT(a_verdict_source, $rose(out_valid_q) |-> $past(frame_end), "verdict without last byte")
  `UPF_ASSERT_NEVER(a_no_overrun, frame_end && out_valid_q && !out_if.ready, "verdict overwritten")

endmodule

// ===== verif/upf_verdict_board_pkg.sv =====
package upf_verdict_board_pkg;
  import upf_pkg::*;

  typedef struct packed {
    logic            verdict;
    logic            report;
    logic [LenW-1:0] sample_length;
    logic [OffW-1:0] udp_offset;
    logic [LenW-1:0] frame_length;
  } verdict_t;

  class verdict_scoreboard;
    logic [PortW-1:0] match_port;
    logic [LenW-1:0]  capture_limit;

    logic [LenW-1:0]  byte_count;
    logic [15:0]      ether_type;
    logic [NibW-1:0]  header_words;
    logic [ByteW-1:0] ip_protocol;
    logic [PortW-1:0] source_port;

    verdict_t verdicts_due[$];
    int       errors;

    function new();
      match_port    = MatchPortRst;
      capture_limit = CaptureLimitRst;
      errors        = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_count   = '0;
      ether_type   = '0;
      header_words = '0;
      ip_protocol  = '0;
      source_port  = '0;
    endfunction

    function void set_config(logic [PortW-1:0] port, logic [LenW-1:0] limit);
      match_port    = port;
      capture_limit = limit;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    // Header capture and the per-frame decision for one accepted byte.
    function void note_byte(logic [ByteW-1:0] b, logic last);
      int unsigned pos;
      int unsigned off;
      int unsigned len;
      verdict_t    v;
      pos = byte_count;
      if (pos == PosEthTypeHi) ether_type[15:8] = b;
      else if (pos == PosEthTypeLo) ether_type[7:0] = b;
      if (pos == PosIhl) header_words = b[NibW-1:0];
      if (pos == PosProto) ip_protocol = b;
      off = EthHdrLen + 4 * header_words;
      if (pos == off) source_port[15:8] = b;
      else if (pos == off + 1) source_port[7:0] = b;
      len = (pos >= CountMax) ? CountMax : pos + 1;
      byte_count = len[LenW-1:0];
      if (!last) return;
      v = '0;
      if (len < EthHdrLen) v.verdict = 1'b0;
      else if (ether_type != EtherTypeIpv4) v.verdict = 1'b1;
      else if (len < Ipv4MinEnd) v.verdict = 1'b0;
      else if (ip_protocol != ProtoUdp) v.verdict = 1'b1;
      else if (off + UdpHdrLen > len) v.verdict = 1'b0;
      else begin
        v.verdict = 1'b1;
        if (source_port == match_port) begin
          v.report        = 1'b1;
          v.sample_length = (len < capture_limit) ? len[LenW-1:0] : capture_limit;
          v.udp_offset    = off[OffW-1:0];
        end
      end
      v.frame_length = len[LenW-1:0];
      verdicts_due.push_back(v);
      clear_frame();
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict transfer with none outstanding");
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      compare_field("verdict", 16'(want.verdict), 16'(got.verdict));
      compare_field("report", 16'(want.report), 16'(got.report));
      compare_field("sample_length", want.sample_length, got.sample_length);
      compare_field("udp_offset", 16'(want.udp_offset), 16'(got.udp_offset));
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

endpackage

// ===== verif/udp_port_frame_classifier_test.sv =====
module udp_port_frame_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  import upf_pkg::*;
  import upf_verdict_board_pkg::*;

  typedef logic [ByteW-1:0] frame_bytes_t [$];

  localparam int unsigned StallLimit = 5000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                calm;
  logic [PortW-1:0]    cur_port;
  int unsigned         quiet_cycles;
  int unsigned         bytes_sent;

  upf_in_if  in_if ();
  upf_out_if out_if ();

  verdict_scoreboard board;

  udp_port_frame_classifier u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
  end

  // Handshakes are sampled mid-cycle, where everything is settled.
  always @(negedge clk_i) begin
    verdict_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.verdict       = out_if.verdict;
        got.report        = out_if.report;
        got.sample_length = out_if.sample_length;
        got.udp_offset    = out_if.udp_offset;
        got.frame_length  = out_if.frame_length;
        board.check_verdict(got);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic frame_bytes_t make_frame(int unsigned len, logic [15:0] etype,
                                              logic [NibW-1:0] ihl, logic [ByteW-1:0] proto,
                                              logic [PortW-1:0] port);
    frame_bytes_t q;
    int unsigned  off;
    q = {};
    for (int unsigned i = 0; i < len; i++) q.push_back(ByteW'($urandom_range(255)));
    off = EthHdrLen + 4 * ihl;
    if (len > PosEthTypeHi) q[PosEthTypeHi] = etype[15:8];
    if (len > PosEthTypeLo) q[PosEthTypeLo] = etype[7:0];
    if (len > PosIhl) q[PosIhl] = {4'h4, ihl};
    if (len > PosProto) q[PosProto] = proto;
    // port goes in last, so a short header may overwrite earlier fields
    if (len > off) q[off] = port[15:8];
    if (len > off + 1) q[off + 1] = port[7:0];
    return q;
  endfunction

  task automatic send_byte(logic [ByteW-1:0] b, logic last);
    logic took;
    if (!calm && $urandom_range(99) < 25) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.frame_byte <= b;
    in_if.last_byte  <= last;
    do begin
      @(negedge clk_i);
      took = in_if.valid && in_if.ready;
      @(posedge clk_i);
    end while (!took);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_bytes_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // Must be called at the edge that accepted the last byte.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [PortW-1:0] port, logic [LenW-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegMatchPort;
    cfg_wdata_i <= port;
    @(posedge clk_i);
    cfg_idx_i   <= RegCaptureLimit;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.set_config(port, limit);
    cur_port = port;
  endtask

  task automatic send_random_frame();
    int unsigned      kind;
    int unsigned      len;
    logic [NibW-1:0]  ihl;
    logic [PortW-1:0] port;
    kind = $urandom_range(99);
    len  = $urandom_range(34, 110);
    ihl  = ($urandom_range(99) < 80) ? NibW'(5) : NibW'($urandom_range(15));
    port = ($urandom_range(99) < 60) ? cur_port : PortW'($urandom_range(16'hFFFF));
    if (kind < 70) begin
      send_frame(make_frame(len, EtherTypeIpv4, ihl, ProtoUdp, port));
    end else if (kind < 78) begin
      send_frame(make_frame(len, 16'($urandom_range(16'hFFFF)), ihl, ProtoUdp, port));
    end else if (kind < 85) begin
      send_frame(make_frame(len, EtherTypeIpv4, ihl, ByteW'($urandom_range(255)), port));
    end else begin
      send_frame(make_frame($urandom_range(1, 40), ($urandom_range(1) != 0) ?
                            EtherTypeIpv4 : 16'($urandom_range(16'hFFFF)),
                            NibW'($urandom_range(15)), ProtoUdp, port));
    end
  endtask

  initial begin
    frame_bytes_t q;
    int unsigned  n;
    logic [PortW-1:0] port;
    logic [LenW-1:0]  limit;
    board            = new();
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = RegMatchPort;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.frame_byte = '0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    calm             = 1'b0;
    cur_port         = MatchPortRst;
    quiet_cycles     = 0;
    bytes_sent       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset configuration
    send_frame(make_frame(1, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(13, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(14, 16'h86DD, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(14, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(33, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(34, EtherTypeIpv4, NibW'(5), 8'd6, PortW'(53)));
    send_frame(make_frame(41, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(42, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(53)));
    send_frame(make_frame(60, EtherTypeIpv4, NibW'(5), ProtoUdp, PortW'(54)));
    send_frame(make_frame(40, EtherTypeIpv4, NibW'(0), ProtoUdp, PortW'(53)));
    send_frame(make_frame(40, EtherTypeIpv4, NibW'(2), ProtoUdp, 16'h0011));
    send_frame(make_frame(40, EtherTypeIpv4, NibW'(4), ProtoUdp, PortW'(53)));
    send_frame(make_frame(82, EtherTypeIpv4, NibW'(15), ProtoUdp, PortW'(53)));
    send_frame(make_frame(81, EtherTypeIpv4, NibW'(15), ProtoUdp, PortW'(53)));
    q = {};
    repeat (30) q.push_back(8'hFF);
    send_frame(q);
    drain();

    write_config(16'h0000, 16'h0000);
    send_frame(make_frame(50, EtherTypeIpv4, NibW'(5), ProtoUdp, 16'h0000));
    send_frame(make_frame(36, EtherTypeIpv4, NibW'(2), ProtoUdp, 16'h0011));
    drain();

    write_config(16'hFFFF, 16'hFFFF);
    send_frame(make_frame(100, EtherTypeIpv4, NibW'(5), ProtoUdp, 16'hFFFF));
    drain();

    write_config(MatchPortRst, 16'd40);
    send_frame(make_frame(70, EtherTypeIpv4, NibW'(5), ProtoUdp, MatchPortRst));

    // random frames
    n = 0;
    while (bytes_sent < 1800) begin
      if (n % 5 == 4) begin
        drain();
        case ($urandom_range(3))
          0: port = 16'h0000;
          1: port = 16'hFFFF;
          2: port = MatchPortRst;
          default: port = PortW'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(3))
          0: limit = 16'h0000;
          1: limit = 16'hFFFF;
          2: limit = LenW'($urandom_range(120));
          default: limit = CaptureLimitRst;
        endcase
        write_config(port, limit);
      end else if ($urandom_range(99) < 10) begin
        drain();
      end
      calm <= (n >= 2 && n < 8);
      send_random_frame();
      n++;
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
